[rtl/mexp_pkg.sv]
// shared constants for the modular exponentiation block
`timescale 1ns / 1ps

package mexp_pkg;

   // width of every field word on the channels
   localparam int FIELD_WIDTH = 32;

   // number of low bits of each input field that take part in the arithmetic
   localparam int OPERAND_WIDTH = 32;

   // reduction step counter, counts 0 .. OPERAND_WIDTH-1
   localparam int COUNT_WIDTH = (OPERAND_WIDTH > 1) ? $clog2(OPERAND_WIDTH) : 1;

endpackage

[rtl/mexp_ifs.sv]
// valid/ready channel interfaces for request and response words
`timescale 1ns / 1ps

interface mexp_req_if;
   logic                              valid;
   logic                              ready;
   logic [mexp_pkg::FIELD_WIDTH-1:0]  base;
   logic [mexp_pkg::FIELD_WIDTH-1:0]  exponent;
   logic [mexp_pkg::FIELD_WIDTH-1:0]  modulus;

   modport source (output valid, output base, output exponent, output modulus, input ready);
   modport sink   (input valid, input base, input exponent, input modulus, output ready);
endinterface

interface mexp_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [mexp_pkg::FIELD_WIDTH-1:0]  power_result;
   logic                              divide_error;

   modport source (output valid, output power_result, output divide_error, input ready);
   modport sink   (input valid, input power_result, input divide_error, output ready);
endinterface

[rtl/mexp_modmul.sv]
// shared modular multiplier: a multiply step then bit-serial restoring reduction
`timescale 1ns / 1ps

module mexp_modmul (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [mexp_pkg::OPERAND_WIDTH-1:0]  op_a,
   input  logic [mexp_pkg::OPERAND_WIDTH-1:0]  op_b,
   input  logic [mexp_pkg::OPERAND_WIDTH-1:0]  modulus,
   output logic                                done,
   output logic [mexp_pkg::OPERAND_WIDTH-1:0]  result
);

   localparam int W  = mexp_pkg::OPERAND_WIDTH;
   localparam int CW = mexp_pkg::COUNT_WIDTH;

   typedef enum logic [2:0] {
      MM_IDLE   = 3'b001,
      MM_MULT   = 3'b010,
      MM_REDUCE = 3'b100
   } mm_state_type;

   mm_state_type   state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           done_ff, done_in;
   logic [W-1:0]   a_ff, b_ff, m_ff;
   logic [W-1:0]   rem_ff, rem_in;
   logic [W-1:0]   low_ff, low_in;

   logic [2*W-1:0] product;
   logic [W:0]     trial;
   logic [W:0]     diff;

   // operands are below the modulus (or the right one is 1), so the high half starts reduced
   assign product = {{W{1'b0}}, a_ff} * {{W{1'b0}}, b_ff};
   assign trial   = {rem_ff, low_ff[W-1]};
   assign diff    = trial - {1'b0, m_ff};

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      rem_in   = rem_ff;
      low_in   = low_ff;
      unique case (state_ff)
         MM_IDLE: begin
            if (start) begin
               state_in = MM_MULT;
            end
         end
         MM_MULT: begin
            rem_in   = product[2*W-1:W];
            low_in   = product[W-1:0];
            count_in = '0;
            state_in = MM_REDUCE;
         end
         MM_REDUCE: begin
            if (diff[W]) begin
               rem_in = trial[W-1:0];
            end else begin
               rem_in = diff[W-1:0];
            end
            low_in   = {low_ff[W-2:0], 1'b0};
            count_in = count_ff + 1'b1;
            if (count_ff == CW'(W - 1)) begin
               done_in  = 1'b1;
               state_in = MM_IDLE;
            end
         end
         default: begin
            state_in = MM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MM_IDLE;
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == MM_IDLE && start) begin
         a_ff <= op_a;
         b_ff <= op_b;
         m_ff <= modulus;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
   end

   assign done   = done_ff;
   assign result = rem_ff;

endmodule

[rtl/modular_exponentiation.sv]
// top level of the right-to-left binary modular exponentiation block
`timescale 1ns / 1ps

// Computes base ** exponent mod modulus by right-to-left square-and-multiply.
// One request word is taken at a time; req_chan.ready is high only while the
// sequencer is idle. All arithmetic runs through a single shared modular
// multiplier: a launch register, the 32x32 product, then a 32-step bit-serial
// restoring reduction. The base is first reduced (one product), then each
// exponent bit up to the highest set bit costs one product when the bit is set
// and one squaring when higher bits remain, and each bit also passes through
// the round decision state. A zero modulus answers 0 with divide_error set,
// and a zero exponent answers 1 without reduction. The finished response word
// sits in an output register until taken, and the next request is accepted as
// soon as the sequencer has handed its result over.
module modular_exponentiation (
   input  logic        clock,
   input  logic        reset,
   mexp_req_if.sink    req_chan,
   mexp_rsp_if.source  rsp_chan
);

   localparam int W  = mexp_pkg::OPERAND_WIDTH;
   localparam int FW = mexp_pkg::FIELD_WIDTH;

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_WAIT_BASE = 6'b000010,
      ST_ROUND     = 6'b000100,
      ST_WAIT_ACC  = 6'b001000,
      ST_WAIT_SQR  = 6'b010000,
      ST_FINISH    = 6'b100000
   } seq_state_type;

   seq_state_type state_ff, state_in;

   // working values of the current word
   logic [W-1:0]  exp_ff, exp_in;
   logic [W-1:0]  mod_ff, mod_in;
   logic [W-1:0]  base_ff, base_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic          err_ff, err_in;

   // multiplier launch
   logic          start_ff, start_in;
   logic [W-1:0]  op_a_ff, op_a_in;
   logic [W-1:0]  op_b_ff, op_b_in;

   // response register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0] rsp_result_ff, rsp_result_in;
   logic          rsp_error_ff, rsp_error_in;

   logic          mm_done;
   logic [W-1:0]  mm_result;
   logic          req_take;
   logic          rsp_free;

   mexp_modmul u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (start_ff),
      .op_a    (op_a_ff),
      .op_b    (op_b_ff),
      .modulus (mod_ff),
      .done    (mm_done),
      .result  (mm_result)
   );

   assign req_take = req_chan.valid && (state_ff == ST_IDLE);
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in      = state_ff;
      exp_in        = exp_ff;
      mod_in        = mod_ff;
      base_in       = base_ff;
      acc_in        = acc_ff;
      err_in        = err_ff;
      start_in      = 1'b0;
      op_a_in       = op_a_ff;
      op_b_in       = op_b_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_result_in = rsp_result_ff;
      rsp_error_in  = rsp_error_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               exp_in  = req_chan.exponent[W-1:0];
               mod_in  = req_chan.modulus[W-1:0];
               base_in = req_chan.base[W-1:0];
               acc_in  = W'(1);
               err_in  = 1'b0;
               if (req_chan.modulus[W-1:0] == '0) begin
                  // zero modulus: flag and answer 0
                  acc_in   = '0;
                  err_in   = 1'b1;
                  state_in = ST_FINISH;
               end else if (req_chan.exponent[W-1:0] == '0) begin
                  // zero exponent: plain 1, not reduced
                  state_in = ST_FINISH;
               end else begin
                  // reduce the base first as base * 1
                  start_in = 1'b1;
                  op_a_in  = req_chan.base[W-1:0];
                  op_b_in  = W'(1);
                  state_in = ST_WAIT_BASE;
               end
            end
         end
         ST_WAIT_BASE: begin
            if (mm_done) begin
               base_in  = mm_result;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            // exponent is nonzero here
            start_in = 1'b1;
            if (exp_ff[0]) begin
               op_a_in  = acc_ff;
               op_b_in  = base_ff;
               state_in = ST_WAIT_ACC;
            end else begin
               op_a_in  = base_ff;
               op_b_in  = base_ff;
               state_in = ST_WAIT_SQR;
            end
         end
         ST_WAIT_ACC: begin
            if (mm_done) begin
               acc_in = mm_result;
               if (exp_ff[W-1:1] == '0) begin
                  // last set bit done, the final squaring is not needed
                  state_in = ST_FINISH;
               end else begin
                  start_in = 1'b1;
                  op_a_in  = base_ff;
                  op_b_in  = base_ff;
                  state_in = ST_WAIT_SQR;
               end
            end
         end
         ST_WAIT_SQR: begin
            if (mm_done) begin
               base_in  = mm_result;
               exp_in   = exp_ff >> 1;
               state_in = ST_ROUND;
            end
         end
         ST_FINISH: begin
            // hand over once the response register is free
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = FW'(acc_ff);
               rsp_error_in  = err_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      exp_ff        <= exp_in;
      mod_ff        <= mod_in;
      base_ff       <= base_in;
      acc_ff        <= acc_in;
      err_ff        <= err_in;
      op_a_ff       <= op_a_in;
      op_b_ff       <= op_b_in;
      rsp_result_ff <= rsp_result_in;
      rsp_error_ff  <= rsp_error_in;
   end

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.power_result = rsp_result_ff;
   assign rsp_chan.divide_error = rsp_error_ff;

endmodule

[sim/mexp_checker.sv]
// response checker for the modular exponentiation block
`timescale 1ns / 1ps

module mexp_checker (
   input  logic   clock,
   input  logic   reset,
   mexp_req_if    req_mon,
   mexp_rsp_if    rsp_mon,
   output int     mismatch_count,
   output int     pending_count
);

   typedef struct packed {
      logic [mexp_pkg::FIELD_WIDTH-1:0] power_result;
      logic                             divide_error;
   } power_word_type;

   power_word_type expected_powers[$];
   int             fail_total = 0;

   assign mismatch_count = fail_total;

   // square-and-multiply, lsb of the exponent first, products at double width
   function automatic power_word_type predict_power(
         logic [mexp_pkg::FIELD_WIDTH-1:0] base_in,
         logic [mexp_pkg::FIELD_WIDTH-1:0] expo_in,
         logic [mexp_pkg::FIELD_WIDTH-1:0] mod_in);
      logic [63:0]     operand_mask;
      logic [63:0]     sq_base;
      logic [63:0]     expo;
      logic [63:0]     modulus;
      logic [63:0]     acc;
      power_word_type  word;
      operand_mask = (64'd1 << mexp_pkg::OPERAND_WIDTH) - 64'd1;
      sq_base      = 64'(base_in) & operand_mask;
      expo         = 64'(expo_in) & operand_mask;
      modulus      = 64'(mod_in) & operand_mask;
      acc          = 64'd1;
      if (modulus == 64'd0) begin
         word.power_result = '0;
         word.divide_error = 1'b1;
         return word;
      end
      for (int round = 0; round < mexp_pkg::OPERAND_WIDTH && expo != 64'd0; round++) begin
         if (expo[0]) begin
            acc = (acc * sq_base) % modulus;
         end
         sq_base = (sq_base * sq_base) % modulus;
         expo    = expo >> 1;
      end
      word.power_result = acc[mexp_pkg::FIELD_WIDTH-1:0] &
                          operand_mask[mexp_pkg::FIELD_WIDTH-1:0];
      word.divide_error = 1'b0;
      return word;
   endfunction

   always @(posedge clock) begin : watch
      power_word_type want;
      if (!reset) begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_powers.size() == 0) begin
               fail_total++;
               if (fail_total <= 10) begin
                  $display("%0t: unexpected response word result=%h error=%b", $time,
                           rsp_mon.power_result, rsp_mon.divide_error);
               end
            end else begin
               want = expected_powers.pop_front();
               if (rsp_mon.power_result !== want.power_result ||
                   rsp_mon.divide_error !== want.divide_error) begin
                  fail_total++;
                  if (fail_total <= 10) begin
                     $display("%0t: mismatch result exp=%h act=%h error exp=%b act=%b",
                              $time, want.power_result, rsp_mon.power_result,
                              want.divide_error, rsp_mon.divide_error);
                  end
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_powers.push_back(predict_power(req_mon.base, req_mon.exponent,
                                                    req_mon.modulus));
         end
      end
      pending_count <= expected_powers.size();
   end

endmodule

[sim/tb.sv]
// testbench top: stimulus, idling and verdict for the modular exponentiation block
`timescale 1ns / 1ps

module tb;

   logic clock;
   logic reset;

   mexp_req_if req_chan ();
   mexp_rsp_if rsp_chan ();

   int mismatch_count;
   int pending_count;

   // sender idling is switched off for whole stretches of words
   bit sender_calm = 1'b0;

   // receiver stall state
   int stall_left = 0;
   int calm_left  = 0;

   modular_exponentiation u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // checker sits beside the block, watching both channels
   mexp_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // 8 ns period
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 15);
      end
      return $urandom_range(20, 80);
   endfunction

   // receiver side: random stalls with occasional long calm stretches where
   // ready stays high, one nonblocking write per edge
   always @(posedge clock) begin : ready_gen
      logic next_ready;
      next_ready = 1'b1;
      if (calm_left > 0) begin
         calm_left--;
      end else if (stall_left > 0) begin
         stall_left--;
         next_ready = 1'b0;
      end else if ($urandom_range(0, 299) == 0) begin
         calm_left = $urandom_range(500, 4000);
      end else if ($urandom_range(0, 9) < 3) begin
         stall_left = pick_gap();
         if (stall_left > 0) begin
            stall_left--;
            next_ready = 1'b0;
         end
      end
      rsp_chan.ready <= next_ready;
   end

   // present one request word after an optional gap and hold it until taken;
   // valid is left high so a back-to-back word needs no lowering
   task automatic offer_request(logic [mexp_pkg::FIELD_WIDTH-1:0] base_w,
                                logic [mexp_pkg::FIELD_WIDTH-1:0] expo_w,
                                logic [mexp_pkg::FIELD_WIDTH-1:0] mod_w);
      int gap;
      gap = sender_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.base     <= base_w;
      req_chan.exponent <= expo_w;
      req_chan.modulus  <= mod_w;
      do begin
         @(posedge clock);
      end while (!req_chan.ready);
   endtask

   // random word shapes: plain random, small moduli, short exponents,
   // zero modulus, zero exponent and large moduli with large bases
   task automatic offer_random_request();
      int                               kind;
      logic [mexp_pkg::FIELD_WIDTH-1:0] base_w;
      logic [mexp_pkg::FIELD_WIDTH-1:0] expo_w;
      logic [mexp_pkg::FIELD_WIDTH-1:0] mod_w;
      kind   = $urandom_range(0, 99);
      base_w = $urandom;
      expo_w = $urandom;
      mod_w  = $urandom;
      if (kind < 45) begin
         // all fields random
      end else if (kind < 62) begin
         mod_w = $urandom_range(1, 15);
      end else if (kind < 80) begin
         // short exponents keep the run brisk
         expo_w = expo_w >> $urandom_range(8, 31);
      end else if (kind < 85) begin
         mod_w = '0;
         if ($urandom_range(0, 3) == 0) begin
            expo_w = '0;
         end
      end else if (kind < 90) begin
         expo_w = '0;
      end else begin
         mod_w  = mod_w | 32'h8000_0000;
         base_w = base_w | 32'hC000_0000;
      end
      offer_request(base_w, expo_w, mod_w);
   endtask

   initial begin : stimulus
      int wait_cycles;
      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.base     <= '0;
      req_chan.exponent <= '0;
      req_chan.modulus  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      // zero modulus flags the error whatever the exponent
      offer_request(32'd5, 32'd0, 32'd0);
      offer_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
      offer_request(32'd0, 32'd7, 32'd0);
      // zero exponent gives 1 unreduced, even for modulus 1
      offer_request(32'd9, 32'd0, 32'd1);
      offer_request(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
      offer_request(32'd0, 32'd0, 32'd13);
      // modulus 1 with a live exponent reduces to 0
      offer_request(32'd7, 32'd3, 32'd1);
      // zero base, small and large moduli
      offer_request(32'd0, 32'd5, 32'd11);
      offer_request(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // unreduced base, well above the modulus
      offer_request(32'd1000, 32'd1, 32'd7);
      offer_request(32'hFFFF_FFFF, 32'd2, 32'd10);
      offer_request(32'hFFFF_FFFE, 32'd5, 32'd3);
      // extremes of every field
      offer_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      offer_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
      offer_request(32'd2, 32'h8000_0000, 32'hFFFF_FFFB);
      offer_request(32'd3, 32'h0000_0001, 32'h8000_0000);
      offer_request(32'd2, 32'd31, 32'd2);
      offer_request(32'hAAAA_AAAA, 32'h5555_5555, 32'hDEAD_BEEF);
      offer_request(32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5677);
      offer_request(32'd4, 32'd13, 32'd497);

      // random part, idle-free stretches for the sender every third block
      for (int i = 0; i < 270; i++) begin
         sender_calm = ((i / 30) % 3) == 2;
         offer_random_request();
      end
      req_chan.valid <= 1'b0;

      // let the checker count the last word before draining
      @(posedge clock);

      // drain what is still in flight, then a margin for stray words
      wait_cycles = 0;
      while (pending_count != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (200) @(posedge clock);

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // watchdog, several times the slowest correct run
   initial begin
      #40_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
